// File: rtl/conv3x3_replicate_border_top_macros.svh
// ----------------------------------------------------------------------------
// conv3x3_replicate_border_top_macros
// assertion helpers shared by the 3x3 convolution block
// ----------------------------------------------------------------------------
`ifndef CONV3X3_REPLICATE_BORDER_TOP_MACROS_SVH
`define CONV3X3_REPLICATE_BORDER_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define C3RB_CHK_NOW(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("c3rb check failed");

// next-cycle implication
`define C3RB_CHK_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("c3rb check failed");

`endif

// File: rtl/c3rb_pkg.sv
// ----------------------------------------------------------------------------
// c3rb_pkg
// shared types and constants of the 3x3 replicate-border convolution
// ----------------------------------------------------------------------------
package c3rb_pkg;

  localparam int PIX_W     = 16;
  localparam int SUM_W     = 35;
  localparam int PROD_W    = 32;
  localparam int PSUM_W    = 34;
  localparam int KROW_W    = 48;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int TAG_W     = 10;
  localparam int IMG_W     = 11;
  localparam int CONV_K    = 3;
  localparam int K_HALF    = CONV_K / 2;
  localparam int NTAP      = CONV_K * CONV_K;
  localparam int TAP_IW    = $clog2(NTAP);

  typedef logic signed [PIX_W-1:0] pix_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;

  localparam cfg_idx_t REG_KTOP   = 3'd0;
  localparam cfg_idx_t REG_KMID   = 3'd1;
  localparam cfg_idx_t REG_KBOT   = 3'd2;
  localparam cfg_idx_t REG_WIDTH  = 3'd3;
  localparam cfg_idx_t REG_HEIGHT = 3'd4;

  typedef struct packed {
    logic [TAG_W-1:0] row;
    logic [TAG_W-1:0] col;
    logic             frame_end;
  } tag_t;

  typedef struct packed {
    pix_t [NTAP-1:0] taps;
    tag_t            tag;
  } req_t;

  function automatic pix_t coef(input logic [KROW_W-1:0] krow, input int j);
    coef = pix_t'(krow[j*PIX_W +: PIX_W]);
  endfunction

endpackage

// File: rtl/c3rb_in_if.sv
// ----------------------------------------------------------------------------
// c3rb_in_if
// pixel request channel
// ----------------------------------------------------------------------------
interface c3rb_in_if;
  logic              valid;
  logic              ready;
  c3rb_pkg::pix_t    pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

// File: rtl/c3rb_out_if.sv
// ----------------------------------------------------------------------------
// c3rb_out_if
// filtered result channel
// ----------------------------------------------------------------------------
interface c3rb_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [c3rb_pkg::SUM_W-1:0]   filtered_value;
  logic [c3rb_pkg::TAG_W-1:0]          out_row;
  logic [c3rb_pkg::TAG_W-1:0]          out_column;
  logic                                frame_end;

  modport source (output valid, output filtered_value, output out_row,
                  output out_column, output frame_end, input ready);
  modport sink   (input valid, input filtered_value, input out_row,
                  input out_column, input frame_end, output ready);
endinterface

// File: rtl/c3rb_lstore.sv
// ----------------------------------------------------------------------------
// c3rb_lstore
// line store: one word per column holding the two previous rows
// ----------------------------------------------------------------------------
module c3rb_lstore #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/c3rb_mac.sv
// ----------------------------------------------------------------------------
// c3rb_mac
// nine-tap multiply, two-level add tree and output register
// ----------------------------------------------------------------------------
module c3rb_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [c3rb_pkg::KROW_W-1:0]       kern_top,
  input  logic [c3rb_pkg::KROW_W-1:0]       kern_mid,
  input  logic [c3rb_pkg::KROW_W-1:0]       kern_bot,
  input  logic                              req_valid,
  input  c3rb_pkg::req_t                    req,
  output logic                              req_ready,
  c3rb_out_if.source                        res
);

  localparam int PW = c3rb_pkg::PROD_W;
  localparam int SW = c3rb_pkg::PSUM_W;
  localparam int OW = c3rb_pkg::SUM_W;
  localparam int K  = c3rb_pkg::CONV_K;
  localparam int NT = c3rb_pkg::NTAP;

  logic [c3rb_pkg::KROW_W-1:0] kern [K];
  logic signed [PW-1:0] prod_c [NT];
  logic signed [PW-1:0] prod_r [NT];
  logic signed [SW-1:0] psum_r [K];
  logic signed [OW-1:0] sum_r;
  c3rb_pkg::tag_t       m_tag_r, s_tag_r, o_tag_r;
  logic                 m_v_r, s_v_r, o_v_r;
  logic                 o_free, s_free, m_free, take;

  assign kern[0] = kern_top;
  assign kern[1] = kern_mid;
  assign kern[2] = kern_bot;

  assign o_free    = !o_v_r || res.ready;
  assign s_free    = !s_v_r || o_free;
  assign m_free    = !m_v_r || s_free;
  assign req_ready = m_free;
  assign take      = req_valid && m_free;

  always_comb begin
    for (int k = 0; k < NT; k++) begin
      prod_c[k] = PW'(req.taps[k]) * PW'(c3rb_pkg::coef(kern[k / K], k % K));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      s_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      m_v_r <= take || (m_v_r && !s_free);
      s_v_r <= (m_v_r && s_free) || (s_v_r && !o_free);
      o_v_r <= (s_v_r && o_free) || (o_v_r && !res.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      prod_r  <= prod_c;
      m_tag_r <= req.tag;
    end
    if (m_v_r && s_free) begin
      for (int i = 0; i < K; i++) begin
        psum_r[i] <= SW'(prod_r[i*K]) + SW'(prod_r[i*K+1]) + SW'(prod_r[i*K+2]);
      end
      s_tag_r <= m_tag_r;
    end
    if (s_v_r && o_free) begin
      sum_r   <= OW'(psum_r[0]) + OW'(psum_r[1]) + OW'(psum_r[2]);
      o_tag_r <= s_tag_r;
    end
  end

  assign res.valid          = o_v_r;
  assign res.filtered_value = sum_r;
  assign res.out_row        = o_tag_r.row;
  assign res.out_column     = o_tag_r.col;
  assign res.frame_end      = o_tag_r.frame_end;

endmodule

// File: rtl/conv3x3_replicate_border_top.sv
// ----------------------------------------------------------------------------
// conv3x3_replicate_border_top
// 3x3 convolution over a raster pixel stream, borders replicate the edge
// ----------------------------------------------------------------------------
//  channel   dir  payload                                     handshake
//  in_pix    in   pixel_value                                 valid/ready
//  out_res   out  filtered_value, out_row, out_column, f_end  valid/ready
//  cfg       in   cfg_index, cfg_wdata                        cfg_we
//
//  one pixel per cycle while out_res does not stall and each pixel gives
//  at most one result; a pixel with more holds the input until the single
//  mac pipe has taken all; a result passes window update and job load,
//  tap select and multiply, row add, final add
//  reset clears counters, window and pipe valids; line store is not cleared
//  a stalled output backs up through the mac pipe, job register and input
// ----------------------------------------------------------------------------
`include "conv3x3_replicate_border_top_macros.svh"

module conv3x3_replicate_border_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  c3rb_pkg::cfg_idx_t                 cfg_index,
  input  logic [c3rb_pkg::CFG_W-1:0]         cfg_wdata,
  c3rb_in_if.sink                            in_pix,
  c3rb_out_if.source                         out_res
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int PW = c3rb_pkg::PIX_W;
  localparam int TW = c3rb_pkg::TAG_W;
  localparam int IW = c3rb_pkg::IMG_W;
  localparam int KW = c3rb_pkg::KROW_W;
  localparam int K  = c3rb_pkg::CONV_K;
  localparam int NT = c3rb_pkg::NTAP;
  localparam int XW = c3rb_pkg::TAP_IW;

  // configuration
  logic [KW-1:0] ktop_r, kmid_r, kbot_r;
  logic [IW-1:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ktop_r   <= '0;
      kmid_r   <= KW'(48'h10000);
      kbot_r   <= '0;
      width_r  <= IW'(1024);
      height_r <= IW'(1024);
    end else if (cfg_we) begin
      unique case (cfg_index)
        c3rb_pkg::REG_KTOP:   ktop_r   <= cfg_wdata[KW-1:0];
        c3rb_pkg::REG_KMID:   kmid_r   <= cfg_wdata[KW-1:0];
        c3rb_pkg::REG_KBOT:   kbot_r   <= cfg_wdata[KW-1:0];
        c3rb_pkg::REG_WIDTH:  width_r  <= cfg_wdata[IW-1:0];
        c3rb_pkg::REG_HEIGHT: height_r <= cfg_wdata[IW-1:0];
        default: ;
      endcase
    end
  end

  // front: counters and line store read
  logic [CW-1:0] col_r, w_m1, c_eff;
  logic [RW-1:0] row_r, h_m1;
  logic          last_col, last_row, accept;

  always_comb begin
    if (width_r == '0) begin
      w_m1 = '0;
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_m1 = CW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = CW'(width_r - IW'(1));
    end
    if (height_r == '0) begin
      h_m1 = '0;
    end else if (32'(height_r) > MAX_HEIGHT) begin
      h_m1 = RW'(MAX_HEIGHT - 1);
    end else begin
      h_m1 = RW'(height_r - IW'(1));
    end
  end

  assign last_col = col_r >= w_m1;
  assign last_row = row_r >= h_m1;
  assign c_eff    = last_col ? w_m1 : col_r;

  // stage 1: line store data returns, window update and write-back
  logic          s1_v_r, s1_lc_r, s1_lr_r, s1_fwd_r, s1_commit;
  logic [CW-1:0] s1_c_r;
  logic [RW-1:0] s1_r_r;
  c3rb_pkg::pix_t s1_px_r;
  logic [2*PW-1:0] s1_fwd_d_r, ls_rdata, ls_word, ls_wdata;
  c3rb_pkg::pix_t above, above2;
  c3rb_pkg::pix_t [K-1:0]  newcol;
  c3rb_pkg::pix_t [NT-1:0] win_r, win_nxt;

  assign in_pix.ready = !s1_v_r || s1_commit;
  assign accept       = in_pix.valid && in_pix.ready;

  c3rb_lstore #(.DEPTH(MAX_WIDTH), .AW(CW), .DW(2*PW)) u_lstore (
    .clk   (clk),
    .re    (accept),
    .raddr (c_eff),
    .rdata (ls_rdata),
    .we    (s1_commit),
    .waddr (s1_c_r),
    .wdata (ls_wdata)
  );

  // word: upper half two rows up, lower half one row up
  assign ls_word   = s1_fwd_r ? s1_fwd_d_r : ls_rdata;
  assign above     = c3rb_pkg::pix_t'(ls_word[PW-1:0]);
  assign above2    = c3rb_pkg::pix_t'(ls_word[2*PW-1:PW]);
  assign ls_wdata  = {above, s1_px_r};
  assign newcol[0] = above2;
  assign newcol[1] = above;
  assign newcol[2] = s1_px_r;

  always_comb begin
    for (int i = 0; i < K; i++) begin
      for (int j = 0; j < K; j++) begin
        if (s1_c_r == '0 || j == K - 1) begin
          win_nxt[i*K+j] = newcol[i];
        end else begin
          win_nxt[i*K+j] = win_r[i*K+j+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      s1_v_r   <= 1'b0;
      s1_fwd_r <= 1'b0;
      win_r    <= '0;
    end else begin
      if (accept) begin
        col_r    <= last_col ? '0 : col_r + CW'(1);
        if (last_col) begin
          row_r <= last_row ? '0 : row_r + RW'(1);
        end
        // same column written back this cycle: the read sees stale data
        s1_fwd_r <= s1_commit && (c_eff == s1_c_r);
      end
      s1_v_r <= accept || (s1_v_r && !s1_commit);
      if (s1_commit) begin
        win_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r    <= in_pix.pixel_value;
      s1_c_r     <= c_eff;
      s1_r_r     <= row_r;
      s1_lc_r    <= last_col;
      s1_lr_r    <= last_row;
      s1_fwd_d_r <= ls_wdata;
    end
  end

  // job register: up to four results of one pixel, one per cycle while mac_ready
  logic [3:0]     j_mask_r, j_rem, j_mask_new;
  logic [CW-1:0]  j_c_r;
  logic [RW-1:0]  j_r_r;
  logic           j_frame_r, j_issue, j_load_ok, mac_ready, upper, edge_col;
  c3rb_pkg::pix_t [NT-1:0] jwin_r;
  c3rb_pkg::req_t req;
  logic [1:0]     rs [K];
  logic [1:0]     cs [K];
  logic [XW-1:0]  tidx;

  assign j_rem     = j_mask_r & (j_mask_r - 4'd1);
  assign j_issue   = (j_mask_r != 4'd0) && mac_ready;
  assign j_load_ok = (j_mask_r == 4'd0) || (j_issue && j_rem == 4'd0);
  assign s1_commit = s1_v_r && j_load_ok;

  assign j_mask_new[0] = (s1_r_r != '0) && (s1_c_r != '0);
  assign j_mask_new[1] = (s1_r_r != '0) && s1_lc_r;
  assign j_mask_new[2] = s1_lr_r && (s1_c_r != '0);
  assign j_mask_new[3] = s1_lr_r && s1_lc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_mask_r <= 4'd0;
    end else if (s1_commit) begin
      j_mask_r <= j_mask_new;
    end else if (j_issue) begin
      j_mask_r <= j_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_commit) begin
      jwin_r    <= win_nxt;
      j_c_r     <= s1_c_r;
      j_r_r     <= s1_r_r;
      j_frame_r <= s1_lc_r && s1_lr_r;
    end
  end

  // lowest pending result first: previous row before this row, inner before edge
  always_comb begin
    upper    = j_mask_r[0] || j_mask_r[1];
    edge_col = j_mask_r[0] ? 1'b0 : j_mask_r[1] ? 1'b1 : j_mask_r[2] ? 1'b0 : 1'b1;
    if (upper) begin
      rs[0] = (j_r_r == RW'(1)) ? 2'd1 : 2'd0;
      rs[1] = 2'd1;
      rs[2] = 2'd2;
    end else begin
      rs[0] = (j_r_r == '0) ? 2'd2 : 2'd1;
      rs[1] = 2'd2;
      rs[2] = 2'd2;
    end
    if (edge_col) begin
      cs[0] = 2'(c3rb_pkg::K_HALF);
      cs[1] = 2'(K - 1);
      cs[2] = 2'(K - 1);
    end else begin
      cs[0] = 2'd0;
      cs[1] = 2'd1;
      cs[2] = 2'd2;
    end
    for (int i = 0; i < K; i++) begin
      for (int j = 0; j < K; j++) begin
        tidx = XW'(rs[i]) * XW'(K) + XW'(cs[j]);
        req.taps[i*K+j] = jwin_r[tidx];
      end
    end
    req.tag.row       = upper ? TW'(j_r_r - RW'(1)) : TW'(j_r_r);
    req.tag.col       = edge_col ? TW'(j_c_r) : TW'(j_c_r - CW'(1));
    req.tag.frame_end = j_frame_r && (j_rem == 4'd0);
  end

  c3rb_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .kern_top  (ktop_r),
    .kern_mid  (kmid_r),
    .kern_bot  (kbot_r),
    .req_valid (j_mask_r != 4'd0),
    .req       (req),
    .req_ready (mac_ready),
    .res       (out_res)
  );

  `C3RB_CHK_NEXT(a_out_hold, out_res.valid && !out_res.ready, out_res.valid && $stable(out_res.filtered_value))
  `C3RB_CHK_NEXT(a_job_hold, (j_mask_r != 4'd0) && !mac_ready, $stable(j_mask_r))
  `C3RB_CHK_NEXT(a_accept_s1, accept, s1_v_r)

endmodule
